[rtl/rsba_pkg.sv]
// Package with the sizes, codes and types shared by the ring slot bump allocator.
package rsba_pkg;

  localparam int SLOTS        = 16;
  localparam int LUMPS        = 64;
  localparam int LIST_ENTRIES = 8;
  localparam int COMMANDS     = 8;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LUMP_W  = $clog2(LUMPS);
  localparam int ENT_W   = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam int LCNT_W  = $clog2(LIST_ENTRIES + 1);
  localparam int CCNT_W  = $clog2(COMMANDS + 1);
  localparam int LADDR_W = $clog2(LUMPS * LIST_ENTRIES);
  localparam int CNT_W   = LCNT_W + CCNT_W;

  localparam int FILL_W  = 28;
  localparam int ALIGN_W = 17;
  localparam int REF_W   = 10;
  localparam int OFS_W   = 31;
  localparam int CIDX_W  = 3;
  localparam int VAL_W   = FILL_W + 1;
  localparam int BIT_W   = $clog2(VAL_W);

  localparam logic [REF_W-1:0]  REFS_MAX       = 10'd1023;
  localparam logic [FILL_W-1:0] SLOT_SIZE_RST  = 28'd65536;
  localparam logic [ALIGN_W-1:0] ALIGN_RST     = 17'd256;

  typedef enum logic [2:0] {
    CMD_ACQ_LUMP = 3'd0,
    CMD_REL_LUMP = 3'd1,
    CMD_ACQ_CMD  = 3'd2,
    CMD_ACQ_STOR = 3'd3,
    CMD_REL_STOR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_CMD_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_SLOT_SIZE = 1'b0,
    REG_ALIGNMENT = 1'b1
  } reg_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_LUMP  = 9'b000000100,
    S_RLRD  = 9'b000001000,
    S_RLDEC = 9'b000010000,
    S_SLOT  = 9'b000100000,
    S_OFS   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_RND   = 9'b100000000
  } state_e;

endpackage

[rtl/ring_slot_bump_allocator.sv]
// Ring slot bump allocator: lump, slot and command bookkeeping under one sequencer.
//
// One command is taken when start is high and busy is low; busy stays high until
// the command has finished, and the result beat appears on the result ports for
// exactly one cycle with done_o high, in the first cycle in which busy is low
// again. The receiver cannot stall, so it must take every beat. After the accepting
// edge the command is dispatched; acquire_command and unknown commands finish there.
// A lump grant then scans lumps from the hint until one is free or all are locked;
// a storage grant scans slots from the head, then forms the offset; a lump release
// alternates list memory read and refcount update for each listed slot; a storage
// release runs the bit-serial remainder unit that rounds the fill to the alignment,
// one bit per cycle over 29 bits. The user must write configuration over the APB
// port only while the block is idle; the block itself does not enforce it.
module ring_slot_bump_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    cmd_i,
  input  logic [5:0]                    lump_id_i,
  input  logic [5:0]                    start_hint_i,
  input  logic [3:0]                    slot_id_i,
  input  logic [rsba_pkg::FILL_W-1:0]   byte_count_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [5:0]                    granted_lump_o,
  output logic [3:0]                    granted_slot_o,
  output logic [rsba_pkg::OFS_W-1:0]    byte_offset_o,
  output logic [rsba_pkg::FILL_W-1:0]   bytes_free_o,
  output logic [rsba_pkg::CIDX_W-1:0]   command_index_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rsba_pkg::*;

  state_e state_q, state_d;

  logic [FILL_W-1:0]  slot_size_q;
  logic [ALIGN_W-1:0] align_q;

  logic [2:0]        cmd_q;
  logic [5:0]        lump_q;
  logic [5:0]        hint_q;
  logic [3:0]        slot_q;
  logic [FILL_W-1:0] bytes_q;

  logic [FILL_W-1:0] fill_q [SLOTS];
  logic [REF_W-1:0]  refs_q [SLOTS];
  logic [SLOTS-1:0]  slot_lock_q;
  logic [SLOT_W-1:0] head_q;
  logic [LUMPS-1:0]  lump_lock_q;
  logic [LUMPS-1:0]  cnt_vld_q;

  logic [CNT_W-1:0]  cnt_mem [LUMPS];
  logic [CNT_W-1:0]  cnt_rd_q;
  logic              cnt_rd_vld_q;
  logic [SLOT_W-1:0] list_mem [LUMPS*LIST_ENTRIES];
  logic [SLOT_W-1:0] list_rd_q;

  logic [LUMP_W-1:0] lidx_q, lctr_q;
  logic [SLOT_W-1:0] sidx_q, sctr_q;
  logic [LCNT_W-1:0] ent_q;
  logic [VAL_W-1:0]  val_q;
  logic [ALIGN_W-1:0] rem_q;
  logic [BIT_W-1:0]  bit_q;
  logic [FILL_W-1:0] feff_q;

  logic accept;
  logic cfg_we;
  logic [LCNT_W-1:0] slot_cnt;
  logic [CCNT_W-1:0] cmd_cnt;
  logic              lump_ok;

  // Finish strobe and result fields of the current command.
  logic                 fin;
  logic [1:0]           fin_status;
  logic [5:0]           fin_lump;
  logic [CIDX_W-1:0]    fin_cidx;
  logic                 ofs_fin;

  // Memory write controls.
  logic               cnt_we, cnt_clr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic               list_we;
  logic [LADDR_W-1:0] list_waddr, list_raddr;

  // Slot scan terms at the current scan index.
  logic              s_locked;
  logic [FILL_W-1:0] s_fill;
  logic              s_fit;
  logic              s_room;
  logic              s_grant;

  // Remainder step and rounding terms.
  logic [ALIGN_W-1:0] a_eff;
  logic [ALIGN_W:0]   rem2;
  logic [ALIGN_W-1:0] rem_nx;
  logic [VAL_W:0]     rnd;
  logic [FILL_W-1:0]  rnd_sat;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register read data.
  always_comb begin
    if (reg_e'(paddr[2]) == REG_ALIGNMENT) begin
      prdata = {{(32-ALIGN_W){1'b0}}, align_q};
    end else begin
      prdata = {{(32-FILL_W){1'b0}}, slot_size_q};
    end
  end

  assign slot_cnt = cnt_rd_vld_q ? cnt_rd_q[LCNT_W-1:0] : '0;
  assign cmd_cnt  = cnt_rd_vld_q ? cnt_rd_q[CNT_W-1:LCNT_W] : '0;
  assign lump_ok  = (int'(lump_q) < LUMPS);

  assign s_locked = slot_lock_q[sidx_q];
  assign s_fill   = (refs_q[sidx_q] == '0) ? '0 : fill_q[sidx_q];
  assign s_fit    = ({1'b0, s_fill} + {1'b0, bytes_q}) < {1'b0, slot_size_q};
  assign s_room   = (int'(slot_cnt) < LIST_ENTRIES);
  assign s_grant  = !s_locked && s_fit && s_room;

  assign a_eff  = (align_q == '0) ? ALIGN_W'(1) : align_q;
  assign rem2   = {rem_q, val_q[bit_q]};
  assign rem_nx = (rem2 >= {1'b0, a_eff}) ? ALIGN_W'(rem2 - {1'b0, a_eff})
                                          : rem2[ALIGN_W-1:0];
  assign rnd    = (rem_q == '0) ? {1'b0, val_q}
                : ({1'b0, val_q} - (VAL_W+1)'(rem_q) + (VAL_W+1)'(a_eff));
  assign rnd_sat = (rnd > (VAL_W+1)'({FILL_W{1'b1}})) ? {FILL_W{1'b1}} : rnd[FILL_W-1:0];

  assign list_raddr = LADDR_W'(lump_q) * LADDR_W'(LIST_ENTRIES) + LADDR_W'(ent_q[ENT_W-1:0]);
  assign list_waddr = LADDR_W'(lump_q) * LADDR_W'(LIST_ENTRIES)
                    + LADDR_W'(slot_cnt[ENT_W-1:0]);

  // Sequencer: next state, finish and memory writes.
  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_lump   = '0;
    fin_cidx   = '0;
    ofs_fin    = 1'b0;
    cnt_we     = 1'b0;
    cnt_clr    = 1'b0;
    cnt_wdata  = cnt_rd_q;
    list_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DISP;
      end
      S_DISP: begin
        case (cmd_q)
          CMD_ACQ_LUMP: state_d = S_LUMP;
          CMD_REL_LUMP: begin
            if (lump_ok) begin
              state_d = S_RLRD;
            end else begin
              fin     = 1'b1;
              state_d = S_IDLE;
            end
          end
          CMD_ACQ_CMD: begin
            fin     = 1'b1;
            state_d = S_IDLE;
            if (!lump_ok) begin
              fin_status = ST_EXHAUSTED;
            end else if (int'(cmd_cnt) < COMMANDS) begin
              fin_cidx  = CIDX_W'(cmd_cnt);
              cnt_we    = 1'b1;
              cnt_wdata = {CCNT_W'(cmd_cnt + 1'b1), slot_cnt};
            end else begin
              fin_status = ST_CMD_FULL;
            end
          end
          CMD_ACQ_STOR: begin
            if (lump_ok) begin
              state_d = S_SLOT;
            end else begin
              fin        = 1'b1;
              fin_status = ST_EXHAUSTED;
              state_d    = S_IDLE;
            end
          end
          CMD_REL_STOR: begin
            if (int'(slot_q) < SLOTS) begin
              state_d = S_DIV;
            end else begin
              fin     = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_LUMP: begin
        if (!lump_lock_q[lidx_q]) begin
          fin      = 1'b1;
          fin_lump = 6'(lidx_q);
          state_d  = S_IDLE;
        end else if (int'(lctr_q) == LUMPS - 1) begin
          fin        = 1'b1;
          fin_status = ST_EXHAUSTED;
          state_d    = S_IDLE;
        end
      end
      S_RLRD: begin
        if (ent_q == slot_cnt) begin
          cnt_clr = 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RLDEC;
        end
      end
      S_RLDEC: state_d = S_RLRD;
      S_SLOT: begin
        if (s_grant) begin
          list_we   = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = {cmd_cnt, LCNT_W'(slot_cnt + 1'b1)};
          state_d   = S_OFS;
        end else if (int'(sctr_q) == SLOTS - 1) begin
          fin        = 1'b1;
          fin_status = ST_EXHAUSTED;
          state_d    = S_IDLE;
        end
      end
      S_OFS: begin
        fin     = 1'b1;
        ofs_fin = 1'b1;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (bit_q == '0) state_d = S_RND;
      end
      S_RND: begin
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Lump count memory with its registered read port.
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[lump_q] <= cnt_wdata;
    if (accept) cnt_rd_q <= cnt_mem[lump_id_i];
  end

  // Lump slot list memory with its registered read port.
  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_waddr] <= sidx_q;
    list_rd_q <= list_mem[list_raddr];
  end

  // Command latch and scan working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      lump_q  <= lump_id_i;
      hint_q  <= start_hint_i;
      slot_q  <= slot_id_i;
      bytes_q <= byte_count_i;
    end
    case (state_q)
      S_DISP: begin
        lidx_q <= LUMP_W'(hint_q);
        lctr_q <= '0;
        sidx_q <= head_q;
        sctr_q <= '0;
        ent_q  <= '0;
        rem_q  <= '0;
        bit_q  <= BIT_W'(VAL_W - 1);
        val_q  <= {1'b0, fill_q[slot_q[SLOT_W-1:0]]} + {1'b0, bytes_q};
      end
      S_LUMP: begin
        lidx_q <= (int'(lidx_q) == LUMPS - 1) ? '0 : LUMP_W'(lidx_q + 1'b1);
        lctr_q <= LUMP_W'(lctr_q + 1'b1);
      end
      S_RLDEC: ent_q <= LCNT_W'(ent_q + 1'b1);
      S_SLOT: begin
        feff_q <= s_fill;
        if (!s_grant) begin
          sidx_q <= (int'(sidx_q) == SLOTS - 1) ? '0 : SLOT_W'(sidx_q + 1'b1);
          sctr_q <= SLOT_W'(sctr_q + 1'b1);
        end
      end
      S_DIV: begin
        rem_q <= rem_nx;
        bit_q <= BIT_W'(bit_q - 1'b1);
      end
      default: ;
    endcase
  end

  // Result beat registers.
  always_ff @(posedge clk_i) begin
    if (fin) begin
      status_o        <= fin_status;
      granted_lump_o  <= fin_lump;
      command_index_o <= fin_cidx;
      granted_slot_o  <= ofs_fin ? 4'(sidx_q) : '0;
      byte_offset_o   <= ofs_fin ? OFS_W'(32'(sidx_q) * 32'(slot_size_q) + 32'(feff_q)) : '0;
      bytes_free_o    <= ofs_fin ? FILL_W'(slot_size_q - feff_q) : '0;
    end
  end

  // Control state, configuration and per-slot, per-lump state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_o       <= 1'b0;
      slot_size_q  <= SLOT_SIZE_RST;
      align_q      <= ALIGN_RST;
      slot_lock_q  <= '0;
      lump_lock_q  <= '0;
      cnt_vld_q    <= '0;
      cnt_rd_vld_q <= 1'b0;
      head_q       <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        fill_q[i] <= '0;
        refs_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_o  <= fin;
      if (cfg_we) begin
        if (reg_e'(paddr[2]) == REG_ALIGNMENT) begin
          align_q <= pwdata[ALIGN_W-1:0];
        end else begin
          slot_size_q <= pwdata[FILL_W-1:0];
        end
      end
      if (accept) cnt_rd_vld_q <= cnt_vld_q[lump_id_i];
      if (cnt_we) cnt_vld_q[lump_q] <= 1'b1;
      if (cnt_clr) begin
        cnt_vld_q[lump_q]   <= 1'b0;
        lump_lock_q[lump_q] <= 1'b0;
      end
      // Lump grant.
      if (state_q == S_LUMP && !lump_lock_q[lidx_q]) lump_lock_q[lidx_q] <= 1'b1;
      // Reference drop for one listed slot.
      if (state_q == S_RLDEC && refs_q[list_rd_q] != '0) begin
        refs_q[list_rd_q] <= REF_W'(refs_q[list_rd_q] - 1'b1);
      end
      // Slot scan: clear the fill of an unreferenced slot, grant on fit.
      if (state_q == S_SLOT && !s_locked) begin
        fill_q[sidx_q] <= s_fill;
        if (s_grant) begin
          slot_lock_q[sidx_q] <= 1'b1;
          head_q              <= sidx_q;
          if (refs_q[sidx_q] < REFS_MAX) refs_q[sidx_q] <= REF_W'(refs_q[sidx_q] + 1'b1);
        end
      end
      // Storage release: rounded fill and unlock.
      if (state_q == S_RND) begin
        fill_q[slot_q[SLOT_W-1:0]]      <= rnd_sat;
        slot_lock_q[slot_q[SLOT_W-1:0]] <= 1'b0;
      end
    end
  end

endmodule
